>>> src/mwac_pkg.sv
package mwac_pkg;

    localparam int TEMP_W    = 8;
    localparam int RAW_W     = 12;
    localparam int FRAC_W    = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam cfg_idx_t REG_TEMP_LOW  = 2'd0;
    localparam cfg_idx_t REG_TEMP_HIGH = 2'd1;

    localparam temp_t TEMP_LOW_RESET  = -8'sd55;
    localparam temp_t TEMP_HIGH_RESET = 8'sd125;

endpackage

>>> src/mwac_med_cell.sv
module mwac_med_cell
    import mwac_pkg::*;
#(
    parameter int DEPTH = 5,
    parameter int IDX   = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  temp_t d_in,
    input  temp_t win [DEPTH],
    input  temp_t sel_in,
    output temp_t sel_out,
    output temp_t q
);

    localparam int RANK_W = $clog2(DEPTH);

    temp_t             val_reg;
    logic [RANK_W-1:0] rank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (shift_en)
        begin
            val_reg <= d_in;
        end
    end

    // stable rank: ties ordered by position so exactly one cell is the median
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if ((win[j] < val_reg) || ((j < IDX) && (win[j] == val_reg)))
            begin
                rank = rank + RANK_W'(1);
            end
        end
    end

    assign sel_out = (rank == RANK_W'(DEPTH / 2)) ? val_reg : sel_in;
    assign q       = val_reg;

endmodule

>>> src/mwac_avg_cell.sv
module mwac_avg_cell
    import mwac_pkg::*;
#(
    parameter int DEPTH = 5,
    parameter int IDX   = 0,
    parameter int SUM_W = 13
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift_en,
    input  temp_t                   d_in,
    input  logic signed [SUM_W-1:0] psum_in,
    output logic signed [SUM_W-1:0] psum_out,
    output temp_t                   q
);

    // newest entry carries the heaviest weight
    localparam logic signed [SUM_W-1:0] WGT = SUM_W'(DEPTH - IDX);

    temp_t val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (shift_en)
        begin
            val_reg <= d_in;
        end
    end

    assign psum_out = psum_in + SUM_W'(val_reg) * WGT;
    assign q        = val_reg;

endmodule

>>> src/median_weighted_average_conditioner_core.sv
// Temperature conditioner: each sample (1/16 degree, with error flag) is rounded half away
// from zero to whole degrees, clamped to the configured band, passed through a median of
// MEDIAN_DEPTH and then a weighted moving average of AVERAGE_DEPTH (weights AVERAGE_DEPTH..1,
// newest heaviest, truncated toward zero). Until a window has filled, its input passes
// straight through. An error sample leaves all state alone and returns the previous filtered
// value and raw sample with reading_valid low. One sample is accepted every cycle unless
// stalled; the registered stages are clamp/median window, median select/average window,
// weighted sum, reciprocal multiply and divide correction into the output register. The two
// windows are rows of shift cells; median cells rank themselves against the row and average
// cells accumulate the weighted sum along it. The user must write limits via the cfg port
// (index 0 low, 1 high) only while the pipeline is empty; the block does not enforce it.
module median_weighted_average_conditioner_core
    import mwac_pkg::*;
#(
    parameter int MEDIAN_DEPTH  = 5,
    parameter int AVERAGE_DEPTH = 5
)
(
    input  logic     clk,
    input  logic     rst_n,

    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_idx_t cfg_index,
    input  temp_t    cfg_data,

    input  logic     in_valid,
    output logic     in_stall,
    input  logic     sensor_error,
    input  raw_t     raw_sixteenths,

    output logic     out_valid,
    input  logic     out_stall,
    output temp_t    filtered_degrees,
    output logic     reading_valid,
    output raw_t     last_good_raw
);

    localparam int MED_CNT_W = $clog2(MEDIAN_DEPTH + 1);
    localparam int AVG_CNT_W = $clog2(AVERAGE_DEPTH + 1);
    localparam int AVG_TOTAL = AVERAGE_DEPTH * (AVERAGE_DEPTH + 1) / 2;
    localparam int SUM_W     = TEMP_W + $clog2(AVG_TOTAL) + 1;
    localparam int MAG_W     = SUM_W - 1;
    localparam int RECIP_SH  = MAG_W + 1;
    localparam int RECIP_W   = RECIP_SH;
    localparam int RECIP     = (1 << RECIP_SH) / AVG_TOTAL;
    localparam int PROD_W    = MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [MAG_W-1:0]   TOTAL_C = MAG_W'(AVG_TOTAL);

    // configuration
    temp_t low_reg;
    temp_t high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= TEMP_LOW_RESET;
            high_reg <= TEMP_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_LOW:  low_reg  <= cfg_data;
                REG_TEMP_HIGH: high_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // pipeline control
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic in_xfer, push1, push2, load5;

    assign rdy5     = !out_vld_reg || !out_stall;
    assign rdy4     = !s4_vld_reg || rdy5;
    assign rdy3     = !s3_vld_reg || rdy4;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign in_stall = !rdy1;
    assign in_xfer  = in_valid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_vld_reg  <= in_valid;
            if (rdy2) s2_vld_reg  <= s1_vld_reg;
            if (rdy3) s3_vld_reg  <= s2_vld_reg;
            if (rdy4) s4_vld_reg  <= s3_vld_reg;
            if (rdy5) out_vld_reg <= s4_vld_reg;
        end
    end

    // stage 1: round and clamp
    logic signed [RAW_W:0]  raw_ext;
    logic [RAW_W:0]         raw_mag;
    logic [RAW_W:0]         rnd_sum;
    logic [TEMP_W:0]        rnd_mag;
    logic signed [TEMP_W:0] v9;
    temp_t                  clamped;

    always_comb
    begin
        raw_ext = (RAW_W + 1)'(raw_sixteenths);
        raw_mag = raw_ext[RAW_W] ? (RAW_W + 1)'(-raw_ext) : (RAW_W + 1)'(raw_ext);
        rnd_sum = raw_mag + (RAW_W + 1)'(8);
        rnd_mag = rnd_sum[FRAC_W +: TEMP_W + 1];
        v9      = raw_ext[RAW_W] ? $signed(-rnd_mag) : $signed(rnd_mag);
        // low first, then high: an inverted band gives high
        if (v9 < (TEMP_W + 1)'(low_reg))
        begin
            v9 = (TEMP_W + 1)'(low_reg);
        end
        if (v9 > (TEMP_W + 1)'(high_reg))
        begin
            v9 = (TEMP_W + 1)'(high_reg);
        end
        clamped = temp_t'(v9);
    end

    assign push1 = in_xfer && !sensor_error;

    logic [MED_CNT_W-1:0] med_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med_cnt_reg <= '0;
        end
        else if (push1 && (med_cnt_reg != MED_CNT_W'(MEDIAN_DEPTH)))
        begin
            med_cnt_reg <= med_cnt_reg + MED_CNT_W'(1);
        end
    end

    logic  s1_err_reg, s1_mfull_reg;
    raw_t  s1_raw_reg;
    temp_t s1_v_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_err_reg   <= sensor_error;
            s1_raw_reg   <= raw_sixteenths;
            s1_v_reg     <= clamped;
            s1_mfull_reg <= (med_cnt_reg >= MED_CNT_W'(MEDIAN_DEPTH - 1));
        end
    end

    // median window row
    temp_t med_win [MEDIAN_DEPTH];
    temp_t med_sel [MEDIAN_DEPTH + 1];

    assign med_sel[0] = '0;

    for (genvar i = 0; i < MEDIAN_DEPTH; i++)
    begin : g_med
        temp_t d_in;
        if (i == 0)
        begin : g_head
            assign d_in = clamped;
        end
        else
        begin : g_body
            assign d_in = med_win[i-1];
        end
        mwac_med_cell #(
            .DEPTH (MEDIAN_DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (push1),
            .d_in     (d_in),
            .win      (med_win),
            .sel_in   (med_sel[i]),
            .sel_out  (med_sel[i+1]),
            .q        (med_win[i])
        );
    end

    // stage 2: median select
    temp_t med_item;

    assign med_item = s1_mfull_reg ? med_sel[MEDIAN_DEPTH] : s1_v_reg;
    assign push2    = rdy2 && s1_vld_reg && !s1_err_reg;

    logic [AVG_CNT_W-1:0] avg_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_cnt_reg <= '0;
        end
        else if (push2 && (avg_cnt_reg != AVG_CNT_W'(AVERAGE_DEPTH)))
        begin
            avg_cnt_reg <= avg_cnt_reg + AVG_CNT_W'(1);
        end
    end

    logic  s2_err_reg, s2_afull_reg;
    raw_t  s2_raw_reg;
    temp_t s2_med_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_err_reg   <= s1_err_reg;
            s2_raw_reg   <= s1_raw_reg;
            s2_med_reg   <= med_item;
            s2_afull_reg <= (avg_cnt_reg >= AVG_CNT_W'(AVERAGE_DEPTH - 1));
        end
    end

    // average window row
    temp_t                   avg_win  [AVERAGE_DEPTH];
    logic signed [SUM_W-1:0] avg_psum [AVERAGE_DEPTH + 1];

    assign avg_psum[0] = '0;

    for (genvar i = 0; i < AVERAGE_DEPTH; i++)
    begin : g_avg
        temp_t d_in;
        if (i == 0)
        begin : g_head
            assign d_in = med_item;
        end
        else
        begin : g_body
            assign d_in = avg_win[i-1];
        end
        mwac_avg_cell #(
            .DEPTH (AVERAGE_DEPTH),
            .IDX   (i),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (push2),
            .d_in     (d_in),
            .psum_in  (avg_psum[i]),
            .psum_out (avg_psum[i+1]),
            .q        (avg_win[i])
        );
    end

    // stage 3: weighted sum, split into sign and magnitude
    logic signed [SUM_W-1:0] wsum;

    assign wsum = avg_psum[AVERAGE_DEPTH];

    logic             s3_err_reg, s3_afull_reg, s3_neg_reg;
    raw_t             s3_raw_reg;
    temp_t            s3_med_reg;
    logic [MAG_W-1:0] s3_mag_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_err_reg   <= s2_err_reg;
            s3_raw_reg   <= s2_raw_reg;
            s3_med_reg   <= s2_med_reg;
            s3_afull_reg <= s2_afull_reg;
            s3_neg_reg   <= wsum[SUM_W-1];
            s3_mag_reg   <= wsum[SUM_W-1] ? MAG_W'(-wsum) : MAG_W'(wsum);
        end
    end

    // stage 4: quotient estimate by reciprocal, at most one low
    logic [PROD_W-1:0] recip_prod;

    assign recip_prod = PROD_W'(s3_mag_reg) * PROD_W'(RECIP_C);

    logic             s4_err_reg, s4_afull_reg, s4_neg_reg;
    raw_t             s4_raw_reg;
    temp_t            s4_med_reg;
    logic [MAG_W-1:0] s4_mag_reg;
    logic [MAG_W-1:0] s4_q0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_err_reg   <= s3_err_reg;
            s4_raw_reg   <= s3_raw_reg;
            s4_med_reg   <= s3_med_reg;
            s4_afull_reg <= s3_afull_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_mag_reg   <= s3_mag_reg;
            s4_q0_reg    <= MAG_W'(recip_prod >> RECIP_SH);
        end
    end

    // stage 5: correct quotient, restore sign, pick pass-through
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quot;
    temp_t            avg_val;
    temp_t            filt;

    always_comb
    begin
        rem     = s4_mag_reg - MAG_W'(s4_q0_reg * TOTAL_C);
        quot    = (rem >= TOTAL_C) ? (s4_q0_reg + MAG_W'(1)) : s4_q0_reg;
        avg_val = s4_neg_reg ? temp_t'(-quot) : temp_t'(quot);
        filt    = s4_afull_reg ? avg_val : s4_med_reg;
    end

    assign load5 = rdy5 && s4_vld_reg;

    // output registers double as the held values for error samples
    temp_t filt_reg;
    raw_t  raw_out_reg;
    logic  rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg    <= '0;
            raw_out_reg <= '0;
            rv_reg      <= 1'b0;
        end
        else if (load5)
        begin
            rv_reg <= !s4_err_reg;
            if (!s4_err_reg)
            begin
                filt_reg    <= filt;
                raw_out_reg <= s4_raw_reg;
            end
        end
    end

    assign out_valid        = out_vld_reg;
    assign filtered_degrees = filt_reg;
    assign reading_valid    = rv_reg;
    assign last_good_raw    = raw_out_reg;

endmodule

>>> tb/tb_median_weighted_average_conditioner_core.sv
module tb_median_weighted_average_conditioner_core;
    import mwac_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int MED_DEPTH       = 5;
    localparam int AVG_DEPTH       = 5;
    localparam int WEIGHT_TOTAL    = AVG_DEPTH * (AVG_DEPTH + 1) / 2;
    localparam int RESET_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int NUM_DIRECTED    = 22;
    localparam int ERROR_PCT       = 12;

    typedef struct {
        temp_t filtered;
        logic  valid;
        raw_t  raw;
    } reading_t;

    // Expected readings: clamp, median of five, weighted average, held on error
    class reading_predictor;
        int low_limit;
        int high_limit;
        int median_win[MED_DEPTH];
        int average_win[AVG_DEPTH];
        int median_fill;
        int average_fill;
        int held_filtered;
        int held_raw;
        int mismatches;
        reading_t pending_readings[$];

        function new();
            low_limit     = TEMP_LOW_RESET;
            high_limit    = TEMP_HIGH_RESET;
            median_fill   = 0;
            average_fill  = 0;
            held_filtered = 0;
            held_raw      = 0;
            mismatches    = 0;
            foreach (median_win[i])
                median_win[i] = 0;
            foreach (average_win[i])
                average_win[i] = 0;
        endfunction

        function void set_limit(cfg_idx_t idx, temp_t value);
            if (idx == REG_TEMP_LOW)
                low_limit = value;
            else if (idx == REG_TEMP_HIGH)
                high_limit = value;
        endfunction

        function int median_of_window();
            int sorted[MED_DEPTH];
            int key;
            int j;
            foreach (median_win[i])
                sorted[i] = median_win[i];
            for (int i = 1; i < MED_DEPTH; i++)
            begin
                key = sorted[i];
                j = i - 1;
                while (j >= 0 && sorted[j] > key)
                begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            return sorted[MED_DEPTH / 2];
        endfunction

        function int weighted_of_window();
            int acc;
            acc = 0;
            for (int i = 0; i < AVG_DEPTH; i++)
                acc += average_win[i] * (AVG_DEPTH - i);
            return acc / WEIGHT_TOTAL;
        endfunction

        function void note_sample(logic err, raw_t raw);
            reading_t exp_reading;
            int deg;
            int med;
            if (!err)
            begin
                deg = raw;
                // half away from zero
                if (deg >= 0)
                    deg = (deg + 8) / 16;
                else
                    deg = -((8 - deg) / 16);
                if (deg < low_limit)
                    deg = low_limit;
                if (deg > high_limit)
                    deg = high_limit;

                for (int i = MED_DEPTH - 1; i > 0; i--)
                    median_win[i] = median_win[i - 1];
                median_win[0] = deg;
                if (median_fill < MED_DEPTH)
                    median_fill++;
                med = (median_fill < MED_DEPTH) ? deg : median_of_window();

                for (int i = AVG_DEPTH - 1; i > 0; i--)
                    average_win[i] = average_win[i - 1];
                average_win[0] = med;
                if (average_fill < AVG_DEPTH)
                    average_fill++;
                held_filtered = (average_fill < AVG_DEPTH) ? med : weighted_of_window();
                held_raw = raw;
            end
            exp_reading.filtered = temp_t'(held_filtered);
            exp_reading.valid    = !err;
            exp_reading.raw      = raw_t'(held_raw);
            pending_readings.push_back(exp_reading);
        endfunction

        function void check_reading(temp_t filtered, logic valid, raw_t raw);
            reading_t exp_reading;
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: filtered_degrees %0d, reading_valid %0b",
                       filtered, valid);
                mismatches++;
                return;
            end
            exp_reading = pending_readings.pop_front();
            if (filtered !== exp_reading.filtered)
            begin
                $error("filtered_degrees: expected %0d, got %0d", exp_reading.filtered, filtered);
                mismatches++;
            end
            if (valid !== exp_reading.valid)
            begin
                $error("reading_valid: expected %0b, got %0b", exp_reading.valid, valid);
                mismatches++;
            end
            if (raw !== exp_reading.raw)
            begin
                $error("last_good_raw: expected %0d, got %0d", exp_reading.raw, raw);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_readings.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    temp_t    cfg_data;
    logic     in_valid;
    logic     in_stall;
    logic     sensor_error;
    raw_t     raw_sixteenths;
    logic     out_valid;
    logic     out_stall;
    temp_t    filtered_degrees;
    logic     reading_valid;
    raw_t     last_good_raw;

    reading_predictor predictor = new();

    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    int cycle_count = 0;
    int drift_deg;

    median_weighted_average_conditioner_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sensor_error     (sensor_error),
        .raw_sixteenths   (raw_sixteenths),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .filtered_degrees (filtered_degrees),
        .reading_valid    (reading_valid),
        .last_good_raw    (last_good_raw)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall, or one long hold-off so the pipe backs up
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            repeat (LONG_HOLD)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            hold_req = 1'b0;
        end
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            predictor.check_reading(filtered_degrees, reading_valid, last_good_raw);
    end

    function automatic raw_t to_raw(int v);
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return raw_t'(v);
    endfunction

    task automatic send_sample(logic err, raw_t raw);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        sensor_error   <= err;
        raw_sixteenths <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predictor.note_sample(err, raw);
        @(negedge clk);
    endtask

    task automatic send_random_sample();
        logic err;
        raw_t raw;
        int   pick;
        int   deg;
        err  = ($urandom_range(99) < ERROR_PCT);
        pick = $urandom_range(9);
        if (pick < 4)
            raw = raw_t'($urandom_range(4095));
        else if (pick < 7)
        begin
            // around the band edges
            deg = ((pick == 5) ? predictor.low_limit : predictor.high_limit)
                  + int'($urandom_range(6)) - 3;
            raw = to_raw(deg * 16 + int'($urandom_range(16)) - 8);
        end
        else if (pick == 7)
        begin
            deg = int'($urandom_range(255)) - 128;
            raw = to_raw(deg * 16 + ($urandom_range(1) ? 8 : -8));
        end
        else
        begin
            // slow drift, so the windows see related values
            drift_deg += int'($urandom_range(10)) - 5;
            if (drift_deg > 127)
                drift_deg = 127;
            if (drift_deg < -128)
                drift_deg = -128;
            raw = to_raw(drift_deg * 16 + int'($urandom_range(15)));
        end
        send_sample(err, raw);
    endtask

    task automatic write_band(temp_t low, temp_t high);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TEMP_LOW;
        cfg_data  <= low;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predictor.set_limit(REG_TEMP_LOW, low);
        @(negedge clk);
        cfg_index <= REG_TEMP_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        predictor.set_limit(REG_TEMP_HIGH, high);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (predictor.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int    phase_low[NUM_PHASES];
        int    phase_high[NUM_PHASES];
        int    idle_mode[4];
        int    stall_mode[4];
        logic  directed_err[NUM_DIRECTED];
        int    directed_raw[NUM_DIRECTED];

        phase_low   = '{-128, -20, 60, 0, -128, 127, -55, 0};
        phase_high  = '{127, 40, -60, 0, -128, 127, 125, 0};
        idle_mode   = '{0, 52, 0, 13};
        stall_mode  = '{0, 0, 52, 13};
        // zero, rounding either side of a half, band extremes, rounding overflow,
        // -127 degrees as plain data, error samples holding the last reading
        directed_raw = '{0, 7, 8, -7, -8, -9, 24, -24, 2047, -2048, 2040, -2040,
                         2039, -2032, 2047, -2048, 880, -880, 2000, -881, 1999, 8};
        directed_err = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                         0, 0, 1, 1, 0, 0, 0, 1, 0, 0};

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TEMP_LOW;
        cfg_data       = '0;
        in_valid       = 1'b0;
        sensor_error   = 1'b0;
        raw_sixteenths = '0;
        out_stall      = 1'b0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_req       = 1'b0;
        drift_deg      = 20;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_sample(directed_err[i], to_raw(directed_raw[i]));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                phase_low[p]  = int'($urandom_range(255)) - 128;
                phase_high[p] = int'($urandom_range(255)) - 128;
            end
            tx_idle_pct  = idle_mode[p % 4];
            rx_stall_pct = stall_mode[p % 4];
            write_band(temp_t'(phase_low[p]), temp_t'(phase_high[p]));
            if (p == 0)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_random_sample();
            drain();
        end

        if (predictor.mismatches == 0 && predictor.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
